FILE: src/firlp_pkg.sv
// ----------------------------------------------------------------------------
// firlp_pkg
// shared constants and coefficient table for the low-pass fir filter
// ----------------------------------------------------------------------------
package firlp_pkg;

	// coefficient format: signed q1.15, values fit in 14 bits
	localparam int COEF_W      = 14;
	localparam int COEF_COUNT  = 30;
	localparam int FRAC_BITS   = 15;

	// products summed per group in the first adder stage
	localparam int GROUP_SIZE  = 8;

	// window size register
	localparam int WINDOW_W    = 5;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd30;

	// coefficient j of the low-pass set, zero past the table
	function automatic logic signed [COEF_W-1:0] coef_at(input int idx);
		logic signed [COEF_W-1:0] c;
		case (idx)
			0:  c = -14'sd37;
			1:  c = -14'sd123;
			2:  c = -14'sd99;
			3:  c =  14'sd53;
			4:  c =  14'sd235;
			5:  c =  14'sd266;
			6:  c =  14'sd9;
			7:  c = -14'sd496;
			8:  c = -14'sd973;
			9:  c = -14'sd990;
			10: c = -14'sd178;
			11: c =  14'sd1541;
			12: c =  14'sd3827;
			13: c =  14'sd6010;
			14: c =  14'sd7340;
			15: c =  14'sd7340;
			16: c =  14'sd6010;
			17: c =  14'sd3827;
			18: c =  14'sd1541;
			19: c = -14'sd178;
			20: c = -14'sd990;
			21: c = -14'sd973;
			22: c = -14'sd496;
			23: c =  14'sd9;
			24: c =  14'sd266;
			25: c =  14'sd235;
			26: c =  14'sd53;
			27: c = -14'sd99;
			28: c = -14'sd124;
			29: c = -14'sd37;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: src/firlp_taps.sv
// ----------------------------------------------------------------------------
// firlp_taps
// delay line and per-tap coefficient multiply
// ----------------------------------------------------------------------------
module firlp_taps #(
	parameter int TAPS         = 30,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            in_valid,
	output logic                                            in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]                  sample,
	input  logic [firlp_pkg::WINDOW_W-1:0]                  window_size,
	output logic                                            out_valid,
	input  logic                                            out_ready,
	output logic signed [SAMPLE_WIDTH+firlp_pkg::COEF_W-1:0] prod [TAPS]
);

	localparam int PW = SAMPLE_WIDTH + firlp_pkg::COEF_W;
	localparam int WW = $clog2(TAPS + 1);

	logic signed [SAMPLE_WIDTH-1:0]      delay_s1 [TAPS];
	logic                                valid_s1;
	logic signed [PW-1:0]                prod_s2 [TAPS];
	logic                                valid_s2;
	logic                                ready_s2;
	logic [WW-1:0]                       w_eff;
	logic signed [firlp_pkg::COEF_W-1:0] coef [TAPS];

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	// clamp window to 1 .. TAPS
	always_comb begin
		if (window_size == '0) begin
			w_eff = WW'(1);
		end else if (32'(window_size) > TAPS) begin
			w_eff = WW'(TAPS);
		end else begin
			w_eff = WW'(window_size);
		end
	end

	// tap k holds the k-th newest sample and takes coef[w-1-k]
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			if (k < 32'(w_eff)) begin
				coef[k] = firlp_pkg::coef_at(32'(w_eff) - 1 - k);
			end else begin
				coef[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int k = 0; k < TAPS; k++) begin
				delay_s1[k] <= '0;
			end
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				delay_s1[0] <= sample;
				for (int k = 1; k < TAPS; k++) begin
					delay_s1[k] <= delay_s1[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			for (int k = 0; k < TAPS; k++) begin
				prod_s2[k] <= PW'(delay_s1[k]) * PW'(coef[k]);
			end
		end
	end

	assign out_valid = valid_s2;
	assign prod      = prod_s2;

endmodule

FILE: src/firlp_sum.sv
// ----------------------------------------------------------------------------
// firlp_sum
// first adder level: products summed in groups
// ----------------------------------------------------------------------------
module firlp_sum #(
	parameter int TAPS         = 30,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              in_valid,
	output logic                                              in_ready,
	input  logic signed [SAMPLE_WIDTH+firlp_pkg::COEF_W-1:0]  prod [TAPS],
	output logic                                              out_valid,
	input  logic                                              out_ready,
	output logic signed [SAMPLE_WIDTH+firlp_pkg::COEF_W+2:0]  grp
		[(TAPS + firlp_pkg::GROUP_SIZE - 1) / firlp_pkg::GROUP_SIZE]
);

	localparam int GS = firlp_pkg::GROUP_SIZE;
	localparam int NG = (TAPS + GS - 1) / GS;
	localparam int GW = SAMPLE_WIDTH + firlp_pkg::COEF_W + 3;

	logic signed [GW-1:0] grp_s3 [NG];
	logic signed [GW-1:0] grp_d  [NG];
	logic                 valid_s3;

	assign in_ready = !valid_s3 || out_ready;

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int e = 0; e < GS; e++) begin
				if (g * GS + e < TAPS) begin
					grp_d[g] = grp_d[g] + GW'(prod[g * GS + e]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			grp_s3 <= grp_d;
		end
	end

	assign out_valid = valid_s3;
	assign grp       = grp_s3;

endmodule

FILE: src/firlp_out.sv
// ----------------------------------------------------------------------------
// firlp_out
// final sum, round half up, saturate, result register
// ----------------------------------------------------------------------------
module firlp_out #(
	parameter int TAPS         = 30,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              in_valid,
	output logic                                              in_ready,
	input  logic signed [SAMPLE_WIDTH+firlp_pkg::COEF_W+2:0]  grp
		[(TAPS + firlp_pkg::GROUP_SIZE - 1) / firlp_pkg::GROUP_SIZE],
	output logic                                              filtered_valid,
	input  logic                                              filtered_stall,
	output logic signed [SAMPLE_WIDTH-1:0]                    filtered
);

	localparam int GS    = firlp_pkg::GROUP_SIZE;
	localparam int NG    = (TAPS + GS - 1) / GS;
	localparam int GW    = SAMPLE_WIDTH + firlp_pkg::COEF_W + 3;
	localparam int ACC_W = GW + 3;

	localparam logic signed [ACC_W-1:0] HALF =
		ACC_W'(64'sd1 <<< (firlp_pkg::FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] HI =
		ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] LO = -HI - ACC_W'(1);

	logic signed [ACC_W-1:0]        acc;
	logic signed [ACC_W-1:0]        quo;
	logic signed [SAMPLE_WIDTH-1:0] sat;
	logic signed [SAMPLE_WIDTH-1:0] filtered_q;
	logic                           valid_q;

	assign in_ready = !valid_q || !filtered_stall;

	always_comb begin
		acc = '0;
		for (int g = 0; g < NG; g++) begin
			acc = acc + ACC_W'(grp[g]);
		end
		// arithmetic shift is a floor divide
		quo = (acc + HALF) >>> firlp_pkg::FRAC_BITS;
		if (quo > HI) begin
			sat = SAMPLE_WIDTH'(HI);
		end else if (quo < LO) begin
			sat = SAMPLE_WIDTH'(LO);
		end else begin
			sat = SAMPLE_WIDTH'(quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			filtered_q <= sat;
		end
	end

	assign filtered_valid = valid_q;
	assign filtered       = filtered_q;

endmodule

FILE: src/fir_lowpass_30tap.sv
// ----------------------------------------------------------------------------
// fir_lowpass_30tap
// direct-form low-pass fir filter, signed q1.15 coefficients
// ----------------------------------------------------------------------------
//
// channel    direction  transfer condition                payload
// ---------  ---------  --------------------------------  -----------
// sample     in         sample_valid && !sample_stall     sample
// filtered   out        filtered_valid && !filtered_stall filtered
// cfg        in         cfg_wr_en (no wait)               cfg_wr_data
//
// one sample per clock sustained while the output is not stalled; the
// delay line takes the sample at the transfer edge, then the products,
// group sums and result register are registered in turn
// reset clears the delay line to zeros, window size to 30, all valids
// each stage holds while the stage after it is full and stalled, so stalls
// back up one stage at a time and bubbles get squeezed out
// ----------------------------------------------------------------------------
module fir_lowpass_30tap #(
	parameter int TAPS         = 30,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample,
	output logic                              filtered_valid,
	input  logic                              filtered_stall,
	output logic signed [SAMPLE_WIDTH-1:0]    filtered,
	input  logic                              cfg_wr_en,
	input  logic [firlp_pkg::WINDOW_W-1:0]    cfg_wr_data
);

	localparam int PW = SAMPLE_WIDTH + firlp_pkg::COEF_W;
	localparam int NG = (TAPS + firlp_pkg::GROUP_SIZE - 1) / firlp_pkg::GROUP_SIZE;
	localparam int GW = PW + 3;

	// window size register; the user must write it only while the pipe is empty, the block does not enforce this
	logic [firlp_pkg::WINDOW_W-1:0] window_size_q;

	// stage hookups
	logic                 taps_ready;
	logic                 prod_valid;
	logic                 sum_ready;
	logic signed [PW-1:0] prod [TAPS];
	logic                 grp_valid;
	logic                 out_ready;
	logic signed [GW-1:0] grp [NG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= firlp_pkg::WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_size_q <= cfg_wr_data;
		end
	end

	assign sample_stall = !taps_ready;

	// delay line plus multiply, one lane per tap
	firlp_taps #(
		.TAPS        (TAPS),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_taps (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample_valid),
		.in_ready   (taps_ready),
		.sample     (sample),
		.window_size(window_size_q),
		.out_valid  (prod_valid),
		.out_ready  (sum_ready),
		.prod       (prod)
	);

	// partial sums of up to eight products each
	firlp_sum #(
		.TAPS        (TAPS),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (prod_valid),
		.in_ready (sum_ready),
		.prod     (prod),
		.out_valid(grp_valid),
		.out_ready(out_ready),
		.grp      (grp)
	);

	// final add, rounding, saturation and result register
	firlp_out #(
		.TAPS        (TAPS),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (grp_valid),
		.in_ready      (out_ready),
		.grp           (grp),
		.filtered_valid(filtered_valid),
		.filtered_stall(filtered_stall),
		.filtered      (filtered)
	);

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for fir_lowpass_30tap
// streams samples through the low-pass filter under random valid/stall
// traffic and checks every filtered transfer against a cycle-free model of
// the delay line, the q1.15 tap sum, rounding and saturation, across
// several window sizes including 0, 1, 30 and 31
// ----------------------------------------------------------------------------

// models the filter one sample at a time and holds the outputs still owed
class lowpass_tracker;
	int                               coef_q15[30];
	logic signed [15:0]               history[30];
	logic [firlp_pkg::WINDOW_W-1:0]   window_reg;
	logic signed [15:0]               filtered_due[$];
	int                               failures;

	function new();
		coef_q15 = '{-37, -123, -99, 53, 235, 266, 9, -496, -973, -990,
			-178, 1541, 3827, 6010, 7340, 7340, 6010, 3827, 1541, -178,
			-990, -973, -496, 9, 266, 235, 53, -99, -124, -37};
		foreach (history[i]) history[i] = '0;
		window_reg = firlp_pkg::WINDOW_RESET;
		failures = 0;
	endfunction

	function void set_window(logic [firlp_pkg::WINDOW_W-1:0] value);
		window_reg = value;
	endfunction

	// zero acts as one tap, anything above the table as the full table
	function int eff_window();
		if (window_reg == 0) return 1;
		if (window_reg > 30) return 30;
		return int'(window_reg);
	endfunction

	function int outstanding();
		return filtered_due.size();
	endfunction

	function void note_sample(logic signed [15:0] value);
		longint acc;
		longint rounded;
		int w;
		for (int i = 29; i > 0; i--) history[i] = history[i-1];
		history[0] = value;
		w = eff_window();
		acc = 0;
		// coefficient 0 meets the oldest sample in the window
		for (int j = 0; j < w; j++)
			acc += longint'(coef_q15[j]) * longint'(history[w-1-j]);
		rounded = (acc + 64'sd16384) >>> 15;
		if (rounded > 32767) rounded = 32767;
		if (rounded < -32768) rounded = -32768;
		filtered_due.push_back(rounded[15:0]);
	endfunction

	function void check_filtered(logic signed [15:0] got);
		logic signed [15:0] want;
		if (filtered_due.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected filtered transfer: got %0d", got);
			return;
		end
		want = filtered_due.pop_front();
		if (got !== want) begin
			failures++;
			if (failures <= 10)
				$display("filtered mismatch: expected %0d got %0d", want, got);
		end
	endfunction
endclass

module testbench;

	logic                               clk;
	logic                               arst_n;
	logic                               sample_valid;
	logic                               sample_stall;
	logic signed [15:0]                 sample;
	logic                               filtered_valid;
	logic                               filtered_stall;
	logic signed [15:0]                 filtered;
	logic                               cfg_wr_en;
	logic [firlp_pkg::WINDOW_W-1:0]     cfg_wr_data;

	lowpass_tracker tracker = new();

	int results_seen = 0;    // filtered transfers so far, drives the long hold-off
	int burst_left   = 0;    // samples left in the current sender burst

	fir_lowpass_30tap uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.filtered_valid (filtered_valid),
		.filtered_stall (filtered_stall),
		.filtered       (filtered),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// watch the output side; every filtered transfer is checked in order
	always @(posedge clk) begin
		if (arst_n && filtered_valid && !filtered_stall) begin
			tracker.check_filtered(filtered);
			results_seen++;
		end
	end

	// receiver: stall modes change every so often, from no stall at all up
	// to heavy back-pressure; twice it holds off long enough for the
	// pipeline to fill and push back on the sample side
	initial begin : receiver
		int unsigned mode;
		int unsigned span;
		int unsigned period;
		int unsigned tick;
		int hold_at;
		filtered_stall = 1'b0;
		hold_at = 300;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 150);
			period = $urandom_range(2, 5);
			repeat (span) begin
				@(negedge clk);
				tick++;
				if (results_seen >= hold_at) begin
					filtered_stall = 1'b1;
					repeat (80) @(negedge clk);
					hold_at = (hold_at == 300) ? 1000 : 32'h7fff_ffff;
				end
				case (mode)
					0: filtered_stall = 1'b0;
					1: filtered_stall = ($urandom_range(0, 99) < 30);
					2: filtered_stall = (tick % period == 0);
					default: filtered_stall = ($urandom_range(0, 99) < 75);
				endcase
			end
		end
	end

	// mix of full-range noise, corner values, small and large magnitudes
	function automatic logic signed [15:0] pick_sample();
		logic signed [15:0] v;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			v = 16'($urandom());
		end else if (pick == 4) begin
			case ($urandom_range(0, 4))
				0: v = 16'sh7fff;
				1: v = 16'sh8000;
				2: v = 16'sh0000;
				3: v = 16'shffff;
				default: v = 16'sh0001;
			endcase
		end else if (pick < 7) begin
			v = 16'($urandom_range(0, 600)) - 16'sd300;
		end else begin
			v = 16'($urandom_range(24000, 32767));
			if ($urandom_range(0, 1)) v = ~v;
		end
		return v;
	endfunction

	// offer one sample and hold it until the transfer; the sender runs in
	// bursts with short gaps between them, some bursts long enough to give
	// stretches with valid held high
	task automatic send_sample(input logic signed [15:0] value);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
		end
		sample_valid = 1'b1;
		sample = value;
		do @(posedge clk); while (sample_stall);
		tracker.note_sample(value);
		burst_left--;
		@(negedge clk);
	endtask

	// stop offering and wait for every owed result
	task automatic drain();
		sample_valid = 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
	endtask

	// register writes only go in with the pipeline empty
	task automatic write_window(input logic [firlp_pkg::WINDOW_W-1:0] value);
		drain();
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		tracker.set_window(value);
	endtask

	// one stretch of random traffic; shaped runs push the sum toward either rail
	// or show the impulse and step response of the current window
	task automatic run_segment(inout int count);
		int unsigned kind;
		int len;
		int w;
		bit up;
		logic signed [15:0] level;
		w = tracker.eff_window();
		kind = $urandom_range(0, 19);
		if (kind < 10) begin
			len = $urandom_range(1, 30);
			repeat (len) send_sample(pick_sample());
		end else if (kind < 14) begin
			// sample signs follow the coefficient signs or their opposite, driving the sum toward a rail
			up = $urandom_range(0, 1);
			len = w;
			for (int j = 0; j < w; j++) begin
				if ((tracker.coef_q15[j] >= 0) == up)
					level = 16'sh7fff - 16'($urandom_range(0, 300));
				else
					level = 16'sh8000 + 16'($urandom_range(0, 300));
				send_sample(level);
			end
		end else if (kind < 17) begin
			len = w + 1;
			send_sample(pick_sample());
			repeat (w) send_sample(16'sh0000);
		end else begin
			level = pick_sample();
			len = w + $urandom_range(0, 4);
			repeat (len) send_sample(level);
		end
		count += len;
	endtask

	initial begin : stimulus
		logic signed [15:0] corner_samples[20];
		logic [firlp_pkg::WINDOW_W-1:0] window_plan[10];
		int sent;

		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;

		corner_samples = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff,
			16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100, 16'shff00};

		// first phase runs on the reset window, then the lower limit and the
		// out-of-range values 0 and 31, then 17, 16, 2 and 29, then a couple of random settings
		window_plan = '{5'd30, 5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd2, 5'd29, 5'd0, 5'd0};
		window_plan[8] = 5'($urandom_range(0, 31));
		window_plan[9] = 5'($urandom_range(0, 31));

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 10; p++) begin
			if (p > 0)
				write_window(window_plan[p]);
			else
				// line still holds reset zeros while these go through
				foreach (corner_samples[k]) send_sample(corner_samples[k]);
			sent = 0;
			while (sent < 150) run_segment(sent);
			drain();
		end

		// let anything stray show up before judging
		repeat (12) @(negedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// hard stop if the run hangs
	initial begin : watchdog
		#(2_000_000);
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
src/firlp_pkg.sv
src/firlp_taps.sv
src/firlp_sum.sv
src/firlp_out.sv
src/fir_lowpass_30tap.sv
test/testbench.sv
